// File: rtl/grc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package grc_pkg;

  // Screen and ray limits
  localparam int SCREEN_COLUMNS = 100;
  localparam int SCREEN_ROWS    = 40;
  localparam int MAX_STEPS      = 160;

  // Field widths
  localparam int COL_W  = 7;
  localparam int ROW_W  = 6;
  localparam int CHAR_W = 7;
  localparam int HIT_W  = 8;
  localparam int POS_W  = 12;
  localparam int ANG_W  = 12;
  localparam int SIN_W  = 16;
  localparam int WALL_W = 64;
  localparam int ADDR_W = 3;

  // Derived widths
  localparam int KW     = $clog2(MAX_STEPS + 1);
  localparam int YW     = $clog2(SCREEN_ROWS);
  localparam int NW     = $clog2(SCREEN_ROWS * MAX_STEPS + 1);
  localparam int CW     = NW + 2;
  localparam int DW     = KW + 1;
  localparam int CNT_W  = $clog2(NW);
  localparam int ACC_W  = KW + 24;

  // Column to angle offset: col*512/SCREEN_COLUMNS via reciprocal
  localparam int       RECIP_SHIFT = 30;
  localparam longint   RECIP       = ((64'd1 << RECIP_SHIFT) + SCREEN_COLUMNS - 1)
                                     / SCREEN_COLUMNS;
  localparam int       ANGLE_BASE  = 4096 - 256;

  // Ray cell limits: cell = acc / 163840, 16 cells per axis
  localparam int CELL_LIMIT = 16 * 163840;
  localparam int CELL_SHIFT = 15;

  // Characters
  localparam logic [CHAR_W-1:0] CH_SPACE = 7'd32;
  localparam logic [CHAR_W-1:0] CH_HASH  = 7'd35;
  localparam logic [CHAR_W-1:0] CH_EIGHT = 7'd56;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 7'd43;
  localparam logic [CHAR_W-1:0] CH_COLON = 7'd58;
  localparam logic [CHAR_W-1:0] CH_DOT   = 7'd46;
  localparam logic [CHAR_W-1:0] CH_X     = 7'd120;
  localparam logic [CHAR_W-1:0] CH_DASH  = 7'd45;

  // Register indexes
  localparam logic [ADDR_W-1:0] CFG_WALL0 = 3'd0;
  localparam logic [ADDR_W-1:0] CFG_WALL1 = 3'd1;
  localparam logic [ADDR_W-1:0] CFG_WALL2 = 3'd2;
  localparam logic [ADDR_W-1:0] CFG_WALL3 = 3'd3;
  localparam logic [ADDR_W-1:0] CFG_PX    = 3'd4;
  localparam logic [ADDR_W-1:0] CFG_PY    = 3'd5;
  localparam logic [ADDR_W-1:0] CFG_VA    = 3'd6;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SINE = 7'b0000010,
    S_INIT = 7'b0000100,
    S_STEP = 7'b0001000,
    S_DSET = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_EMIT = 7'b1000000
  } grc_state_e;

  typedef struct packed {
    logic load;
    logic sine;
    logic init;
    logic step;
    logic dset;
    logic div;
    logic emit;
  } grc_cmd_t;

  typedef struct packed {
    logic step_end;
    logic div_done;
    logic emit_free;
    logic emit_last;
  } grc_sts_t;

  // Quarter-wave sine, Q1.14, one entry per 64 angle units
  function automatic logic [14:0] quarter_tab(input logic [4:0] i);
    logic [14:0] v;
    case (i)
      5'd0:    v = 15'd0;
      5'd1:    v = 15'd1606;
      5'd2:    v = 15'd3196;
      5'd3:    v = 15'd4756;
      5'd4:    v = 15'd6270;
      5'd5:    v = 15'd7723;
      5'd6:    v = 15'd9102;
      5'd7:    v = 15'd10394;
      5'd8:    v = 15'd11585;
      5'd9:    v = 15'd12665;
      5'd10:   v = 15'd13623;
      5'd11:   v = 15'd14449;
      5'd12:   v = 15'd15137;
      5'd13:   v = 15'd15678;
      5'd14:   v = 15'd16069;
      5'd15:   v = 15'd16305;
      default: v = 15'd16384;
    endcase
    return v;
  endfunction

  // Interpolated sine of a 12-bit angle, signed Q1.14
  function automatic logic signed [SIN_W-1:0] sine_q14(input logic [ANG_W-1:0] a);
    logic [10:0] t;
    logic [4:0]  i;
    logic [5:0]  f;
    logic [14:0] lo;
    logic [14:0] hi;
    logic [20:0] prod;
    logic [14:0] v;
    t    = a[10] ? (11'd1024 - {1'b0, a[9:0]}) : {1'b0, a[9:0]};
    i    = t[10:6];
    f    = t[5:0];
    lo   = quarter_tab(i);
    hi   = quarter_tab(i + 5'd1);
    prod = 21'(hi - lo) * 21'(f);
    v    = (i >= 5'd16) ? 15'd16384 : lo + 15'(prod >> 6);
    return a[11] ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

endpackage
`default_nettype wire

// File: rtl/grc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module grc_ctrl import grc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  grc_sts_t      sts_i,
  output grc_cmd_t      cmd_o
);

  grc_state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Sequencer: angle, sine, ray march, divide, emit
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SINE;
        end
      end
      S_SINE: begin
        cmd_o.sine = 1'b1;
        state_d    = S_INIT;
      end
      S_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = S_STEP;
      end
      S_STEP: begin
        cmd_o.step = 1'b1;
        if (sts_i.step_end) state_d = S_DSET;
      end
      S_DSET: begin
        cmd_o.dset = 1'b1;
        state_d    = S_DIV;
      end
      S_DIV: begin
        cmd_o.div = 1'b1;
        if (sts_i.div_done) state_d = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        if (sts_i.emit_free && sts_i.emit_last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

endmodule
`default_nettype wire

// File: rtl/grc_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module grc_dp import grc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  grc_cmd_t               cmd_i,
  output grc_sts_t               sts_o,
  input  wire logic [COL_W-1:0]  column_i,
  input  wire logic [255:0]      wall_i,
  input  wire logic [POS_W-1:0]  player_x_i,
  input  wire logic [POS_W-1:0]  player_y_i,
  input  wire logic [ANG_W-1:0]  view_angle_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [ROW_W-1:0]       row_o,
  output logic [CHAR_W-1:0]      pixel_char_o,
  output logic [HIT_W-1:0]       hit_steps_o,
  output logic                   last_o
);

  logic [ANG_W-1:0]          ang_q;
  logic signed [SIN_W-1:0]   sx_q, cy_q;
  logic signed [ACC_W-1:0]   acc_x_q, acc_y_q;
  logic [KW-1:0]             k_q, steps_q;
  logic                      neg_q;
  logic [NW-1:0]             dvd_q;
  logic [DW-1:0]             rem_q, div_q;
  logic [CNT_W-1:0]          cnt_q;
  logic [YW-1:0]             y_q;
  logic                      oval_q;

  // Column to ray angle
  logic [63:0]      quot_prod;
  logic [ANG_W-1:0] ang_d;
  assign quot_prod = 64'(column_i) * 64'(RECIP);
  assign ang_d = view_angle_i + ANG_W'(ANGLE_BASE) + ANG_W'(quot_prod >> (RECIP_SHIFT - 9));

  // Start positions scaled by 640
  logic signed [ACC_W-1:0] px_s, py_s;
  assign px_s = $signed(ACC_W'(player_x_i));
  assign py_s = $signed(ACC_W'(player_y_i));

  // Cell lookup from the current accumulators
  logic        out_x, out_y, out_any, wall_bit;
  logic [6:0]  tx, ty;
  logic [14:0] mx, my;
  logic [3:0]  cx, cy;
  assign out_x   = (acc_x_q < 0) || (acc_x_q >= ACC_W'(CELL_LIMIT));
  assign out_y   = (acc_y_q < 0) || (acc_y_q >= ACC_W'(CELL_LIMIT));
  assign out_any = out_x || out_y;
  assign tx = acc_x_q[CELL_SHIFT+6:CELL_SHIFT];
  assign ty = acc_y_q[CELL_SHIFT+6:CELL_SHIFT];
  assign mx = 15'(tx) * 15'd205;
  assign my = 15'(ty) * 15'd205;
  assign cx = mx[13:10];
  assign cy = my[13:10];
  assign wall_bit = wall_i[{cy, cx}];

  assign sts_o.step_end = out_any || wall_bit || (k_q == KW'(MAX_STEPS));

  // Divider setup: num = ROWS*(steps-20)
  logic signed [CW-1:0] num_s;
  logic [NW-1:0]        mag;
  assign num_s = $signed(CW'(SCREEN_ROWS)) * $signed(CW'(steps_q))
                 - $signed(CW'(20 * SCREEN_ROWS));
  assign mag   = (num_s < 0) ? NW'(-num_s) : NW'(num_s);

  // One restoring step per cycle
  logic [DW:0] rem_sh;
  logic        qbit;
  assign rem_sh = {rem_q, dvd_q[NW-1]};
  assign qbit   = (rem_sh >= {1'b0, div_q});
  assign sts_o.div_done = (cnt_q == CNT_W'(NW - 1));

  // Row shading
  logic signed [CW:0] ceil_s, floor_s, ys;
  logic [YW:0]        up;
  logic [CHAR_W-1:0]  shade, ch;
  assign ceil_s  = neg_q ? -$signed((CW+1)'(dvd_q)) : $signed((CW+1)'(dvd_q));
  assign floor_s = $signed((CW+1)'(SCREEN_ROWS)) - ceil_s;
  assign ys      = $signed((CW+1)'(y_q));
  assign up      = (YW+1)'(SCREEN_ROWS) - (YW+1)'(y_q);

  always_comb begin
    if (4 * steps_q <= MAX_STEPS)      shade = CH_HASH;
    else if (3 * steps_q < MAX_STEPS)  shade = CH_EIGHT;
    else if (2 * steps_q < MAX_STEPS)  shade = CH_PLUS;
    else if (steps_q < MAX_STEPS)      shade = CH_COLON;
    else                               shade = CH_DOT;
    if (ys <= ceil_s)                    ch = CH_SPACE;
    else if (ys <= floor_s)              ch = shade;
    else if (8 * up < SCREEN_ROWS)       ch = CH_X;
    else if (4 * up < SCREEN_ROWS)       ch = CH_DASH;
    else if (8 * up < 3 * SCREEN_ROWS)   ch = CH_DOT;
    else                                 ch = CH_SPACE;
  end

  assign sts_o.emit_free = !oval_q || out_ready_i;
  assign sts_o.emit_last = (y_q == YW'(SCREEN_ROWS - 1));

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) ang_q <= ang_d;
    if (cmd_i.sine) begin
      sx_q <= sine_q14(ang_q);
      cy_q <= sine_q14(ang_q + ANG_W'(1024));
    end
    if (cmd_i.init) begin
      acc_x_q <= (px_s <<< 9) + (px_s <<< 7) + ACC_W'(sx_q);
      acc_y_q <= (py_s <<< 9) + (py_s <<< 7) + ACC_W'(cy_q);
      k_q     <= KW'(1);
    end
    if (cmd_i.step) begin
      if (sts_o.step_end) begin
        steps_q <= (!out_any && wall_bit) ? k_q : KW'(MAX_STEPS);
      end else begin
        acc_x_q <= acc_x_q + ACC_W'(sx_q);
        acc_y_q <= acc_y_q + ACC_W'(cy_q);
        k_q     <= k_q + KW'(1);
      end
    end
    if (cmd_i.dset) begin
      neg_q <= (num_s < 0);
      dvd_q <= mag;
      rem_q <= '0;
      div_q <= {steps_q, 1'b0};
      cnt_q <= '0;
      y_q   <= '0;
    end
    if (cmd_i.div) begin
      rem_q <= qbit ? DW'(rem_sh - {1'b0, div_q}) : DW'(rem_sh);
      dvd_q <= {dvd_q[NW-2:0], qbit};
      cnt_q <= cnt_q + CNT_W'(1);
    end
    if (cmd_i.emit && sts_o.emit_free) begin
      row_o        <= ROW_W'(y_q);
      pixel_char_o <= ch;
      hit_steps_o  <= HIT_W'(steps_q);
      last_o       <= sts_o.emit_last;
      y_q          <= y_q + YW'(1);
    end
  end

  // Output slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)                            oval_q <= 1'b0;
    else if (cmd_i.emit && sts_o.emit_free) oval_q <= 1'b1;
    else if (out_ready_i)                   oval_q <= 1'b0;
  end

  assign out_valid_o = oval_q;

  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (k_q >= KW'(1)) && (k_q <= KW'(MAX_STEPS)))
    else $error("ray step count out of range");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div |-> (div_q != '0))
    else $error("divider has zero divisor");

  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && sts_o.emit_free && sts_o.emit_last) |=>
      (last_o && row_o == ROW_W'(SCREEN_ROWS - 1)))
    else $error("last flag not on bottom row");

endmodule
`default_nettype wire

// File: rtl/grid_raycast_column_renderer_top.sv
// Flow: the column's ray angle and sine are registered, then the ray is marched one step per
// cycle, k the ray steps taken (1 to MAX_STEPS), then the row bounds come from a divider;
// characters are then emitted one per cycle while the output accepts them, and the next
// column is taken only after the last character of the previous column has been issued.
// Reset: asynchronous, active low; walls clear, player at (2.0, 2.0), angle 0, idle.
`timescale 1ns / 1ps
`default_nettype none
module grid_raycast_column_renderer_top import grc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [7:0]        s_axis_tdata,   // [6:0] column
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [23:0]            m_axis_tdata,   // [5:0] row, [12:6] pixel_char, [20:13] hit_steps
  output logic                   m_axis_tlast,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [ADDR_W-1:0] cfg_addr_i,
  input  wire logic [WALL_W-1:0] cfg_data_i
);

  logic [WALL_W-1:0] wall0_q, wall1_q, wall2_q, wall3_q;
  logic [POS_W-1:0]  px_q, py_q;
  logic [ANG_W-1:0]  va_q;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wall0_q <= '0;
      wall1_q <= '0;
      wall2_q <= '0;
      wall3_q <= '0;
      px_q    <= POS_W'(512);
      py_q    <= POS_W'(512);
      va_q    <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        CFG_WALL0: wall0_q <= cfg_data_i;
        CFG_WALL1: wall1_q <= cfg_data_i;
        CFG_WALL2: wall2_q <= cfg_data_i;
        CFG_WALL3: wall3_q <= cfg_data_i;
        CFG_PX:    px_q    <= cfg_data_i[POS_W-1:0];
        CFG_PY:    py_q    <= cfg_data_i[POS_W-1:0];
        CFG_VA:    va_q    <= cfg_data_i[ANG_W-1:0];
        default:   ;
      endcase
    end
  end

  grc_cmd_t          cmd;
  grc_sts_t          sts;
  logic [ROW_W-1:0]  row;
  logic [CHAR_W-1:0] pixel_char;
  logic [HIT_W-1:0]  hit_steps;

  grc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  grc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .column_i     (s_axis_tdata[COL_W-1:0]),
    .wall_i       ({wall3_q, wall2_q, wall1_q, wall0_q}),
    .player_x_i   (px_q),
    .player_y_i   (py_q),
    .view_angle_i (va_q),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .row_o        (row),
    .pixel_char_o (pixel_char),
    .hit_steps_o  (hit_steps),
    .last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, hit_steps, pixel_char, row};

endmodule
`default_nettype wire

// File: test/tb_grid_raycast_column_renderer_top.sv
`timescale 1ns / 1ps
module tb_grid_raycast_column_renderer_top;
  import grc_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [23:0]       m_axis_tdata;
  logic              m_axis_tlast;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [ADDR_W-1:0] cfg_addr_i = '0;
  logic [WALL_W-1:0] cfg_data_i = '0;

  grid_raycast_column_renderer_top dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  typedef struct packed {
    logic [5:0] row;
    logic [6:0] ch;
    logic [7:0] steps;
    logic       last;
  } pixel_t;

  // predictor copy of the registers
  logic [63:0] walls[4];
  logic [11:0] pos_x, pos_y, heading;

  logic [6:0]  column_q[$];
  pixel_t      pixel_q[$];
  int          errors = 0;
  int          hold_cycles = 0;

  function automatic int quarter_val(int t);
    int tab[17] = '{0, 1606, 3196, 4756, 6270, 7723, 9102, 10394, 11585,
                    12665, 13623, 14449, 15137, 15678, 16069, 16305, 16384};
    int i;
    i = t >> 6;
    if (i >= 16) return 16384;
    return tab[i] + (((tab[i+1] - tab[i]) * (t & 63)) >> 6);
  endfunction

  function automatic int sin_of(int a);
    int q, r, v;
    q = (a >> 10) & 3;
    r = a & 1023;
    v = (q & 1) ? quarter_val(1024 - r) : quarter_val(r);
    return (q & 2) ? -v : v;
  endfunction

  function automatic int cell_at(int p, int d, int k);
    longint n;
    n = longint'(p) * 163840 + longint'(d) * k * 256;
    if (n < 0) return -1;
    n = n / 41943040;
    return (n >= 16) ? -1 : int'(n);
  endfunction

  // cast one column's ray and queue its characters
  task automatic render_column(input logic [6:0] col);
    int ang, sx, cy, steps, tx, ty, num, ceil_r, floor_r, up;
    logic [6:0] shade, ch;
    pixel_t px;
    ang = (int'(heading) + 4096 - 256 + (int'(col) * 512) / SCREEN_COLUMNS) & 4095;
    sx = sin_of(ang);
    cy = sin_of((ang + 1024) & 4095);
    steps = MAX_STEPS;
    for (int k = 1; k <= MAX_STEPS; k++) begin
      tx = cell_at(pos_x, sx, k);
      ty = cell_at(pos_y, cy, k);
      if (tx < 0 || ty < 0) break;
      if (walls[ty >> 2][((ty & 3) << 4) + tx]) begin
        steps = k;
        break;
      end
    end
    num = SCREEN_ROWS * (steps - 20);
    ceil_r = (num >= 0) ? num / (2 * steps) : -((-num) / (2 * steps));
    floor_r = SCREEN_ROWS - ceil_r;
    if (4 * steps <= MAX_STEPS) shade = CH_HASH;
    else if (3 * steps < MAX_STEPS) shade = CH_EIGHT;
    else if (2 * steps < MAX_STEPS) shade = CH_PLUS;
    else if (steps < MAX_STEPS) shade = CH_COLON;
    else shade = CH_DOT;
    for (int y = 0; y < SCREEN_ROWS; y++) begin
      up = SCREEN_ROWS - y;
      if (y <= ceil_r) ch = CH_SPACE;
      else if (y <= floor_r) ch = shade;
      else if (8 * up < SCREEN_ROWS) ch = CH_X;
      else if (4 * up < SCREEN_ROWS) ch = CH_DASH;
      else if (8 * up < 3 * SCREEN_ROWS) ch = CH_DOT;
      else ch = CH_SPACE;
      px.row = 6'(y);
      px.ch = ch;
      px.steps = 8'(steps);
      px.last = (y == SCREEN_ROWS - 1);
      pixel_q.push_back(px);
    end
  endtask

  // column driver: bursts with random gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        render_column(s_axis_tdata[6:0]);
        void'(column_q.pop_front());
      end
      // the head of the queue is always the item on the bus or the next one
      if ((s_axis_tvalid && !s_axis_tready) ||
          (column_q.size() > 0 && gap_left == 0)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, column_q[0]};
        if (!(s_axis_tvalid && !s_axis_tready)) begin
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 6);
          end
          burst_left--;
          if (burst_left == 0 && $urandom_range(0, 2) != 0) gap_left = $urandom_range(1, 300);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // character monitor and output stall pattern
  always @(posedge clk_i) begin
    pixel_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.row = m_axis_tdata[5:0];
        got.ch = m_axis_tdata[12:6];
        got.steps = m_axis_tdata[20:13];
        got.last = m_axis_tlast;
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected item: actual %h", $time, got);
          errors++;
        end else begin
          want = pixel_q.pop_front();
          if (got !== want) begin
            $display({"%0t: mismatch row/char/steps/last: expected %0d %0d %0d %0d, ",
                      "actual %0d %0d %0d %0d"},
                     $time, want.row, want.ch, want.steps, want.last,
                     got.row, got.ch, got.steps, got.last);
            errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= (($time / 640) % 3 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
    end
  end

  task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx <= CFG_WALL3) walls[idx] = val;
    else if (idx == CFG_PX) pos_x = val[11:0];
    else if (idx == CFG_PY) pos_y = val[11:0];
    else if (idx == CFG_VA) heading = val[11:0];
  endtask

  task automatic wait_drained;
    while (column_q.size() != 0 || s_axis_tvalid || pixel_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  // random map, with a solid border when border is set
  task automatic random_scene(input bit border);
    logic [63:0] w;
    for (int r = 0; r < 4; r++) begin
      w = {$urandom, $urandom} & {$urandom, $urandom};
      if (border) begin
        for (int j = 0; j < 4; j++) begin
          if (r * 4 + j == 0 || r * 4 + j == 15) w[j*16 +: 16] = 16'hffff;
          w[j*16] = 1'b1;
          w[j*16 + 15] = 1'b1;
        end
      end
      write_reg(ADDR_W'(r), w);
    end
    write_reg(CFG_PX, ($urandom_range(0, 9) == 0) ? 64'($urandom)
                                                  : 64'($urandom_range(0, 4095)));
    write_reg(CFG_PY, ($urandom_range(0, 9) == 0) ? 64'($urandom)
                                                  : 64'($urandom_range(0, 4095)));
    write_reg(CFG_VA, 64'($urandom));
  endtask

  initial begin
    walls = '{default: '0};
    pos_x = 12'd512;
    pos_y = 12'd512;
    heading = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: reset scene (empty map, no wall hit), column extremes
    column_q = '{7'd0, 7'd99, 7'd50, 7'd127, 7'd100};
    wait_drained();
    // player in a wall, all walls
    for (int r = 0; r < 4; r++) write_reg(ADDR_W'(r), '1);
    write_reg(CFG_PX, 64'd0);
    write_reg(CFG_PY, 64'd4095);
    write_reg(CFG_VA, 64'd4095);
    column_q = '{7'd0, 7'd99, 7'd85};
    wait_drained();
    // player at (0, 0) from an out-of-range position write, all walls
    write_reg(CFG_PX, 64'hffff_ffff_ffff_f000);
    write_reg(CFG_PY, 64'd0);
    column_q = '{7'd0, 7'd64};
    wait_drained();
    random_scene(1'b1);
    write_reg(CFG_PX, 64'd2048);
    write_reg(CFG_PY, 64'd2048);
    for (int i = 0; i < 8; i++) column_q.push_back(7'(i * 16));
    wait_drained();
    // random phases; one long output hold per run
    for (int ph = 0; ph < 20; ph++) begin
      random_scene($urandom_range(0, 3) != 0);
      for (int i = 0; i < 16; i++)
        column_q.push_back(($urandom_range(0, 7) == 0) ? 7'($urandom)
                                                        : 7'($urandom_range(0, 99)));
      if (ph == 3) hold_cycles = 3000;
      wait_drained();
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
